// ===== design/acss_pkg.sv =====
// ----------------------------------------------------------------------------
// acss_pkg
// Shared types and constants for the ADC channel scan sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acss_pkg;

  // Number of converter channels scanned round-robin (1 to 8).
  localparam int NUM_CHANNELS = 8;

  // Fixed field widths.
  localparam int CH_W     = 3;
  localparam int WORD_W   = 16;
  localparam int RDCH_W   = 4;
  localparam int DWELL_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;
  localparam int STORE_DEPTH = 8;

  // Operation codes.
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CONFIG_UPDATE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_TYPE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_BANDWIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_SELECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCER_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READBACK_OFF     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_LIMIT      = 3'd6;

  // One input item.
  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] rx_word;
    logic [RDCH_W-1:0] read_channel;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [WORD_W-1:0] tx_word;
    logic              sample_stored;
    logic [CH_W-1:0]   stored_channel;
    logic [WORD_W-1:0] sample_value;
    logic [CH_W-1:0]   active_channel;
  } out_item_t;

  // Write request into the sample store.
  typedef struct packed {
    logic              en;
    logic [CH_W-1:0]   addr;
    logic [WORD_W-1:0] data;
  } store_wr_t;

endpackage

// ===== design/acss_sample_store.sv =====
// ----------------------------------------------------------------------------
// acss_sample_store
// Per-channel sample registers, cleared at reset, one write and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acss_sample_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acss_pkg::store_wr_t           wr,
  input  logic [acss_pkg::CH_W-1:0]     rd_addr,
  output logic [acss_pkg::WORD_W-1:0]   rd_data
);

  logic [acss_pkg::WORD_W-1:0] entry_r [acss_pkg::STORE_DEPTH];

  // Write port; reset clears every entry to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < acss_pkg::STORE_DEPTH; i++) begin
        entry_r[i] <= '0;
      end
    end else if (wr.en) begin
      entry_r[wr.addr] <= wr.data;
    end
  end

  // Read port is a plain multiplexer over the eight entries.
  assign rd_data = entry_r[rd_addr];

endmodule

// ===== design/adc_channel_scan_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// adc_channel_scan_sequencer_unit
// Frame-level scan controller for a multichannel SPI converter.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the input is not stalled and
// returns one result for each: an input register holds the item, and the
// dwell counter, word packing and sample store update happen as it moves into
// the result register. The input side stalls only when both registers are
// full and the result side is stalling. Scan items advance the channel once
// the bumped dwell count exceeds dwell_limit and keep the received word for
// the old channel; read items return a kept sample, or zero for a channel at
// or above the channel count. Configuration is written through cfg_we; the
// user must do so only while the block holds no item; nothing enforces it.
`timescale 1ns / 1ps

module adc_channel_scan_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [acss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acss_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  acss_pkg::in_item_t                in_data,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output acss_pkg::out_item_t               out_data
);

  // Configuration registers.
  logic                               config_update_r;
  logic [2:0]                         input_type_r;
  logic                               full_bandwidth_r;
  logic [2:0]                         reference_select_r;
  logic [1:0]                         sequencer_mode_r;
  logic                               readback_off_r;
  logic [acss_pkg::DWELL_W-1:0]       dwell_limit_r;

  // Scan state.
  logic [acss_pkg::CH_W-1:0]          channel_r, channel_nxt;
  logic [acss_pkg::DWELL_W-1:0]       dwell_r, dwell_nxt;

  // Pipeline registers.
  logic                               s1_valid_r, s1_valid_nxt;
  acss_pkg::in_item_t                 s1_item_r;
  logic                               out_valid_r, out_valid_nxt;
  acss_pkg::out_item_t                out_item_r, out_item_nxt;

  logic                               out_free;
  logic                               advance;
  logic                               in_xfer;

  logic [acss_pkg::DWELL_W:0]         bumped;
  logic [acss_pkg::CH_W:0]            ch_inc;
  logic [acss_pkg::CH_W-1:0]          next_ch;
  logic                               ch_change;
  logic [acss_pkg::WORD_W-1:0]        tx_word;
  acss_pkg::store_wr_t                store_wr;
  logic [acss_pkg::WORD_W-1:0]        store_rd;
  logic                               rd_in_range;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      config_update_r    <= 1'b1;
      input_type_r       <= 3'd7;
      full_bandwidth_r   <= 1'b0;
      reference_select_r <= 3'd0;
      sequencer_mode_r   <= 2'd0;
      readback_off_r     <= 1'b1;
      dwell_limit_r      <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acss_pkg::REG_CONFIG_UPDATE:    config_update_r    <= cfg_wdata[0];
        acss_pkg::REG_INPUT_TYPE:       input_type_r       <= cfg_wdata[2:0];
        acss_pkg::REG_FULL_BANDWIDTH:   full_bandwidth_r   <= cfg_wdata[0];
        acss_pkg::REG_REFERENCE_SELECT: reference_select_r <= cfg_wdata[2:0];
        acss_pkg::REG_SEQUENCER_MODE:   sequencer_mode_r   <= cfg_wdata[1:0];
        acss_pkg::REG_READBACK_OFF:     readback_off_r     <= cfg_wdata[0];
        acss_pkg::REG_DWELL_LIMIT:      dwell_limit_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is
  // empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  // Dwell counter, compared at nine bits, and round-robin channel step.
  assign bumped    = {1'b0, dwell_r} + {{acss_pkg::DWELL_W{1'b0}}, 1'b1};
  assign ch_inc    = {1'b0, channel_r} + {{acss_pkg::CH_W{1'b0}}, 1'b1};
  assign next_ch   = (bumped > {1'b0, dwell_limit_r})
                     ? ((ch_inc >= (acss_pkg::CH_W+1)'(acss_pkg::NUM_CHANNELS))
                        ? '0 : ch_inc[acss_pkg::CH_W-1:0])
                     : channel_r;
  assign ch_change = (next_ch != channel_r);

  // Transmit word: packed configuration word shifted left by two.
  assign tx_word = {config_update_r, input_type_r, next_ch, full_bandwidth_r,
                    reference_select_r, sequencer_mode_r, readback_off_r, 2'b00};

  // Store write for the old channel when a scan changes channel.
  always_comb begin
    store_wr.en   = advance && (s1_item_r.op == acss_pkg::OP_SCAN) && ch_change;
    store_wr.addr = channel_r;
    store_wr.data = s1_item_r.rx_word;
  end

  assign rd_in_range = (s1_item_r.read_channel <
                        acss_pkg::RDCH_W'(acss_pkg::NUM_CHANNELS));

  acss_sample_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (store_wr),
    .rd_addr (s1_item_r.read_channel[acss_pkg::CH_W-1:0]),
    .rd_data (store_rd)
  );

  // Result and next state for the item in the input register.
  always_comb begin
    channel_nxt  = channel_r;
    dwell_nxt    = dwell_r;
    out_item_nxt = '0;
    if (s1_item_r.op == acss_pkg::OP_READ) begin
      out_item_nxt.sample_value   = rd_in_range ? store_rd : '0;
      out_item_nxt.active_channel = channel_r;
    end else begin
      channel_nxt                 = next_ch;
      dwell_nxt                   = ch_change || (bumped > {1'b0, dwell_limit_r})
                                    ? '0 : bumped[acss_pkg::DWELL_W-1:0];
      out_item_nxt.tx_word        = tx_word;
      out_item_nxt.sample_stored  = ch_change;
      out_item_nxt.stored_channel = ch_change ? channel_r : '0;
      out_item_nxt.sample_value   = ch_change ? s1_item_r.rx_word : '0;
      out_item_nxt.active_channel = next_ch;
    end
  end

  // Valid flags of both registers.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      channel_r   <= '0;
      dwell_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        channel_r <= channel_nxt;
        dwell_r   <= dwell_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// ===== design/acss_checker.sv =====
// ----------------------------------------------------------------------------
// acss_checker
// Port-level checks on the scan sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acss_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input acss_pkg::out_item_t out_data
);

  // A stalled result stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // No stored channel is reported unless a sample was kept.
  a_no_store_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sample_stored |-> out_data.stored_channel == '0)
    else $error("stored channel set without a kept sample");

  // A kept sample means the channel moved away from the stored one.
  a_store_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sample_stored
      |-> out_data.active_channel != out_data.stored_channel)
    else $error("sample kept without a channel change");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind adc_channel_scan_sequencer_unit acss_checker u_acss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
